// ===== rtl/bpdc_pkg.sv =====
// Shared types and constants of the button press duration classifier.
// Used by bpdc_lane, bpdc_merge and button_press_duration_classifier.
package bpdc_pkg;

    // Lanes the result word can carry, and the fixed widths of the fields.
    localparam int LANE_MAX    = 8;
    localparam int STATE_BITS  = 3;
    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int STATES_W    = LANE_MAX * STATE_BITS;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SUPERLONG = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET  = 16'd50;
    localparam logic [CFG_BITS-1:0] LONG_RESET      = 16'd1000;
    localparam logic [CFG_BITS-1:0] SUPERLONG_RESET = 16'd3000;

    // Press state codes.
    typedef enum logic [STATE_BITS-1:0] {
        ST_IDLE      = 3'd0,
        ST_SHORT     = 3'd1,
        ST_LONG      = 3'd2,
        ST_SUPER     = 3'd3,
        ST_SHORT_REL = 3'd4,
        ST_LONG_REL  = 3'd5,
        ST_SUPER_REL = 3'd6
    } t_press_state;

    // Thresholds shared by all lanes.
    typedef struct packed {
        logic [CFG_BITS-1:0] debounce;
        logic [CFG_BITS-1:0] long_press;
        logic [CFG_BITS-1:0] superlong_press;
    } t_cfg;

    // What one lane reports for the current word.
    typedef struct packed {
        logic [STATE_BITS-1:0] state;
        logic                  changed;
    } t_lane_out;

endpackage

// ===== rtl/button_press_duration_classifier.sv =====
// Top level of the button press duration classifier.
// Instantiates one bpdc_lane per button and bpdc_merge; uses bpdc_pkg.
//
// Usage: every input word is one millisecond tick carrying the sampled level
// of each button (bit i high means button i is pressed). Each lane tracks how
// long its level has been stable and steps its press state through short,
// long and superlong press, and the matching released states, once the
// level has been stable longer than the debounce threshold.
// Input channel: i_in_valid / o_in_ready with i_pin_levels. Output channel:
// o_out_valid / i_out_ready with o_button_states (3 bits per button) and
// o_changed_mask (bit set where the state moved this tick).
// The result of an accepted word is formed combinationally and registered
// in the output stage. All lanes update in parallel from one compare chain,
// so one word is accepted every cycle while the receiver keeps up.
// The output stage holds two words, so one more word is taken while a result
// waits; when both are full o_in_ready drops until the receiver takes one.
// Reset (synchronous, active low) clears every lane to released level, zero
// count and idle state, empties the output stage and loads the default
// thresholds 50, 1000 and 3000 ticks. The user writes thresholds through
// the configuration port only while idle (unenforced); index 3 is ignored.
module button_press_duration_classifier import bpdc_pkg::*; #(
    parameter int BUTTONS   = 8,
    parameter int TIME_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [LANE_MAX-1:0]     i_pin_levels,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [STATES_W-1:0]     o_button_states,
    output logic [LANE_MAX-1:0]     o_changed_mask,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    t_cfg      r_cfg;
    t_lane_out lane_reports [LANE_MAX];
    logic      accept;

    assign accept = i_in_valid && o_in_ready;

    // Threshold registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce        <= DEBOUNCE_RESET;
            r_cfg.long_press      <= LONG_RESET;
            r_cfg.superlong_press <= SUPERLONG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:  r_cfg.debounce        <= i_cfg_data;
                CFG_LONG:      r_cfg.long_press      <= i_cfg_data;
                CFG_SUPERLONG: r_cfg.superlong_press <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Lanes from index BUTTONS upward are absent and report idle and unchanged.
    for (genvar g = 0; g < LANE_MAX; g++) begin : g_lane
        if (g < BUTTONS) begin : g_used
            bpdc_lane #(
                .TIME_BITS (TIME_BITS)
            ) u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_accept (accept),
                .i_level  (i_pin_levels[g]),
                .i_cfg    (r_cfg),
                .o_report (lane_reports[g])
            );
        end else begin : g_unused
            assign lane_reports[g] = '0;
        end
    end

    bpdc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_lanes     (lane_reports),
        .o_ready     (o_in_ready),
        .o_valid     (o_out_valid),
        .i_pop_ready (i_out_ready),
        .o_states    (o_button_states),
        .o_changed   (o_changed_mask)
    );

endmodule

// ===== rtl/bpdc_lane.sv =====
// One button lane: last level, saturating hold counter and press state.
// Depends on bpdc_pkg for the state codes, threshold and report structs.
module bpdc_lane import bpdc_pkg::*; #(
    parameter int TIME_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  logic      i_level,
    input  t_cfg      i_cfg,
    output t_lane_out o_report
);

    localparam int CMP_W = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
    localparam logic [TIME_BITS-1:0] COUNT_MAX = {TIME_BITS{1'b1}};

    logic                  r_raw;
    logic [TIME_BITS-1:0]  r_held;
    logic [STATE_BITS-1:0] r_state;

    logic                  n_raw;
    logic [TIME_BITS-1:0]  n_held;
    logic [STATE_BITS-1:0] n_state;
    logic [CMP_W-1:0]      held_ext;

    always_comb begin
        n_raw = i_level;
        if (i_level != r_raw) begin
            n_held = '0;
        end else if (r_held != COUNT_MAX) begin
            n_held = r_held + 1'b1;
        end else begin
            n_held = r_held;
        end
        held_ext = CMP_W'(n_held);

        n_state = r_state;
        if (held_ext > CMP_W'(i_cfg.debounce)) begin
            if (i_level) begin
                case (r_state)
                    ST_SHORT: begin
                        if (held_ext > CMP_W'(i_cfg.long_press)) begin
                            n_state = ST_LONG;
                        end
                    end
                    ST_LONG: begin
                        if (held_ext > CMP_W'(i_cfg.superlong_press)) begin
                            n_state = ST_SUPER;
                        end
                    end
                    ST_SUPER: n_state = r_state;
                    default:  n_state = ST_SHORT;
                endcase
            end else begin
                case (r_state)
                    ST_SHORT: n_state = ST_SHORT_REL;
                    ST_LONG:  n_state = ST_LONG_REL;
                    ST_SUPER: n_state = ST_SUPER_REL;
                    default:  n_state = r_state;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw   <= 1'b0;
            r_held  <= '0;
            r_state <= ST_IDLE;
        end else if (i_accept) begin
            r_raw   <= n_raw;
            r_held  <= n_held;
            r_state <= n_state;
        end
    end

    assign o_report.state   = n_state;
    assign o_report.changed = (n_state != r_state);

endmodule

// ===== rtl/bpdc_merge.sv =====
// Packs the lane reports into one result word and holds it in a two-entry
// output stage (main register plus skid register). Depends on bpdc_pkg.
module bpdc_merge import bpdc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_lane_out           i_lanes [LANE_MAX],
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_pop_ready,
    output logic [STATES_W-1:0] o_states,
    output logic [LANE_MAX-1:0] o_changed
);

    logic [STATES_W-1:0] new_states;
    logic [LANE_MAX-1:0] new_changed;

    logic                r_out_valid;
    logic [STATES_W-1:0] r_out_states;
    logic [LANE_MAX-1:0] r_out_changed;
    logic                r_skid_valid;
    logic [STATES_W-1:0] r_skid_states;
    logic [LANE_MAX-1:0] r_skid_changed;

    logic pop;

    always_comb begin
        for (int i = 0; i < LANE_MAX; i++) begin
            new_states[i*STATE_BITS +: STATE_BITS] = i_lanes[i].state;
            new_changed[i]                         = i_lanes[i].changed;
        end
    end

    assign pop = r_out_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || pop) begin
                r_out_valid <= r_skid_valid || i_push;
            end
            if (r_skid_valid) begin
                if (pop) begin
                    r_skid_valid <= i_push;
                end
            end else begin
                r_skid_valid <= i_push && r_out_valid && !pop;
            end
        end
    end

    // Payload registers follow the same steering without reset.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_states  <= r_skid_states;
                r_out_changed <= r_skid_changed;
            end else begin
                r_out_states  <= new_states;
                r_out_changed <= new_changed;
            end
        end
        if (i_push && (r_skid_valid || (r_out_valid && !pop))) begin
            r_skid_states  <= new_states;
            r_skid_changed <= new_changed;
        end
    end

    assign o_ready   = !r_skid_valid;
    assign o_valid   = r_out_valid;
    assign o_states  = r_out_states;
    assign o_changed = r_out_changed;

endmodule

// ===== dv/bpdc_tick_check.sv =====
// Checker for the button press duration classifier: watches both word channels and the
// configuration port, predicts every result word and compares it field by field.
// Depends on bpdc_pkg for widths, register indexes and the press state codes.
module bpdc_tick_check import bpdc_pkg::*; #(
    parameter int BUTTONS   = 8,
    parameter int TIME_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [LANE_MAX-1:0]     i_pin_levels,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [STATES_W-1:0]     i_button_states,
    input  logic [LANE_MAX-1:0]     i_changed_mask,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    output int                      o_fail_count,
    output int                      o_due_count,
    output int                      o_words_in,
    output int                      o_results_out,
    output int                      o_long_hits,
    output int                      o_super_hits
);

    typedef struct packed {
        logic [STATES_W-1:0] states;
        logic [LANE_MAX-1:0] changed;
    } t_tick_result;

    localparam logic [TIME_BITS-1:0] COUNT_TOP = '1;

    t_cfg                 thresholds;
    logic [LANE_MAX-1:0]  lane_level;
    logic [TIME_BITS-1:0] lane_count [LANE_MAX];
    t_press_state         lane_state [LANE_MAX];
    t_tick_result         expected_q [$];
    t_tick_result         oldest;
    int                   fails      = 0;
    int                   due        = 0;
    int                   words      = 0;
    int                   results    = 0;
    int                   long_hits  = 0;
    int                   super_hits = 0;

    assign o_fail_count  = fails;
    assign o_due_count   = due;
    assign o_words_in    = words;
    assign o_results_out = results;
    assign o_long_hits   = long_hits;
    assign o_super_hits  = super_hits;

    task automatic clear_lanes();
        thresholds.debounce        = DEBOUNCE_RESET;
        thresholds.long_press      = LONG_RESET;
        thresholds.superlong_press = SUPERLONG_RESET;
        lane_level = '0;
        for (int i = 0; i < LANE_MAX; i++) begin
            lane_count[i] = '0;
            lane_state[i] = ST_IDLE;
        end
    endtask

    // Advances every lane by one tick and returns the word the block should produce.
    function automatic t_tick_result classify_tick(input logic [LANE_MAX-1:0] levels);
        t_tick_result res;
        t_press_state st;
        t_press_state nx;
        logic         lvl;
        res = '0;
        for (int i = 0; i < BUTTONS; i++) begin
            lvl = levels[i];
            st  = lane_state[i];
            nx  = st;
            if (lvl != lane_level[i]) begin
                lane_level[i] = lvl;
                lane_count[i] = '0;
            end else if (lane_count[i] != COUNT_TOP) begin
                lane_count[i] = lane_count[i] + 1'b1;
            end
            if (lane_count[i] > thresholds.debounce) begin
                if (lvl) begin
                    case (st)
                        ST_SHORT: begin
                            if (lane_count[i] > thresholds.long_press) nx = ST_LONG;
                        end
                        ST_LONG: begin
                            if (lane_count[i] > thresholds.superlong_press) nx = ST_SUPER;
                        end
                        ST_SUPER: nx = ST_SUPER;
                        default:  nx = ST_SHORT;
                    endcase
                end else begin
                    case (st)
                        ST_SHORT: nx = ST_SHORT_REL;
                        ST_LONG:  nx = ST_LONG_REL;
                        ST_SUPER: nx = ST_SUPER_REL;
                        default:  nx = st;
                    endcase
                end
            end
            res.changed[i] = (nx != st);
            res.states[STATE_BITS*i +: STATE_BITS] = nx;
            lane_state[i] = nx;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        fails++;
        if (fails <= 40) begin
            $display("%0t  %s: expected %h, got %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_lanes();
            expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result word with nothing expected", '0,
                                    {i_changed_mask, i_button_states});
                end else begin
                    oldest = expected_q.pop_front();
                    results++;
                    if (i_button_states !== oldest.states) begin
                        report_mismatch("button_states", 32'(oldest.states),
                                        32'(i_button_states));
                    end
                    if (i_changed_mask !== oldest.changed) begin
                        report_mismatch("changed_mask", 32'(oldest.changed),
                                        32'(i_changed_mask));
                    end
                    for (int i = 0; i < BUTTONS; i++) begin
                        if (oldest.changed[i]) begin
                            if (oldest.states[STATE_BITS*i +: STATE_BITS] == ST_LONG) begin
                                long_hits++;
                            end
                            if (oldest.states[STATE_BITS*i +: STATE_BITS] == ST_SUPER) begin
                                super_hits++;
                            end
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_q.push_back(classify_tick(i_pin_levels));
                words++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEBOUNCE:  thresholds.debounce        = i_cfg_data;
                    CFG_LONG:      thresholds.long_press      = i_cfg_data;
                    CFG_SUPERLONG: thresholds.superlong_press = i_cfg_data;
                    default: ;
                endcase
            end
        end
        due <= expected_q.size();
    end

endmodule

// ===== dv/tb.sv =====
// Top of the button press duration classifier testbench: clock, reset, stimulus and verdict.
// Depends on bpdc_pkg, the block button_press_duration_classifier and the checker
// bpdc_tick_check, which does all prediction and comparison.
module tb;
    import bpdc_pkg::*;

    localparam int BUTTONS   = 8;
    localparam int TIME_BITS = 16;

    // Index 3 has no register behind it; writes there must be ignored.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

    // Random holds are capped so the default thresholds stay affordable.
    localparam int HOLD_CAP       = 1100;
    // Time limit for the whole run, well above what the slowest correct run needs.
    localparam int RUN_LIMIT      = 30000000;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [LANE_MAX-1:0]     pin_levels;
    logic                    out_valid;
    logic                    out_ready;
    logic [STATES_W-1:0]     button_states;
    logic [LANE_MAX-1:0]     changed_mask;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    int fail_count;
    int due_count;
    int words_in;
    int results_out;
    int long_hits;
    int super_hits;

    logic [LANE_MAX-1:0] held_levels = '0;
    int                  phase_words;

    button_press_duration_classifier #(
        .BUTTONS   (BUTTONS),
        .TIME_BITS (TIME_BITS)
    ) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_pin_levels    (pin_levels),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_button_states (button_states),
        .o_changed_mask  (changed_mask),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    bpdc_tick_check #(
        .BUTTONS   (BUTTONS),
        .TIME_BITS (TIME_BITS)
    ) u_tick_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_pin_levels    (pin_levels),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_button_states (button_states),
        .i_changed_mask  (changed_mask),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_due_count     (due_count),
        .o_words_in      (words_in),
        .o_results_out   (results_out),
        .o_long_hits     (long_hits),
        .o_super_hits    (super_hits)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Gap lengths: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        else if (r < 92) return $urandom_range(1, 3);
        else return $urandom_range(8, 40);
    endfunction

    // Receiver: stalls of random length between runs of readiness. Every change
    // happens at a falling edge, and each edge sees at most one assignment.
    initial begin
        int stall;
        out_ready = 1'b0;
        @(negedge clk);
        forever begin
            stall = pick_gap();
            if (stall != 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    // Offers one word, called at a falling edge. Valid stays high from the edge
    // it rises until the word is taken, and the task returns at the falling
    // edge after acceptance, so back-to-back words with no gap drawn keep valid high throughout.
    task automatic send_word(input logic [LANE_MAX-1:0] levels);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        pin_levels = levels;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        phase_words++;
    endtask

    // Holds the sender off until every expected result word has been taken.
    // Each word yields exactly one result, so nothing is left in flight after that.
    task automatic drain();
        in_valid = 1'b0;
        while (due_count != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Writes all three thresholds back to back, then pokes the unused index
    // with random data, which the block must ignore. Only called when idle.
    task automatic load_thresholds(input int debounce, input int long_press,
                                   input int superlong_press);
        cfg_we    = 1'b1;
        cfg_index = CFG_DEBOUNCE;
        cfg_data  = debounce[CFG_BITS-1:0];
        @(negedge clk);
        cfg_index = CFG_LONG;
        cfg_data  = long_press[CFG_BITS-1:0];
        @(negedge clk);
        cfg_index = CFG_SUPERLONG;
        cfg_data  = superlong_press[CFG_BITS-1:0];
        @(negedge clk);
        cfg_index = CFG_SPARE;
        cfg_data  = CFG_BITS'($urandom);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // One random phase under a fixed set of thresholds. Most of the traffic is
    // held level patterns, where usually only a few lanes flip between holds so that
    // lanes can stay pressed long enough to climb through short, long and
    // superlong press. Hold lengths are drawn around the thresholds and end at
    // the phase budget. The rest is chatter (a new random level every tick,
    // which keeps resetting the counts) and the odd pause until every result
    // has come back.
    task automatic run_phase(input int debounce, input int long_press,
                             input int superlong_press, input int budget);
        int                  lim;
        int                  hold;
        int                  r;
        logic [LANE_MAX-1:0] flip;
        drain();
        load_thresholds(debounce, long_press, superlong_press);
        lim = debounce;
        if (long_press > lim) lim = long_press;
        if (superlong_press > lim) lim = superlong_press;
        lim = lim + 4;
        if (lim > HOLD_CAP) lim = HOLD_CAP;
        phase_words = 0;
        while (phase_words < budget) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                repeat ($urandom_range(1, 6)) send_word(LANE_MAX'($urandom));
            end else if (r < 14) begin
                drain();
            end else begin
                flip = (r < 30) ? LANE_MAX'($urandom) : LANE_MAX'($urandom & $urandom);
                held_levels = held_levels ^ flip;
                if ($urandom_range(0, 1) == 1) begin
                    hold = $urandom_range(1, (debounce + 3 < lim) ? debounce + 3 : lim);
                end else begin
                    hold = $urandom_range(1, lim);
                end
                if (hold > budget - phase_words) hold = budget - phase_words;
                repeat (hold) send_word(held_levels);
            end
        end
    endtask

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        pin_levels = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_DEBOUNCE;
        cfg_data   = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed, default thresholds: all-off, all-on, alternating bits, single
        // lanes and chatter. Nothing can pass a 50-tick debounce here, so every
        // lane must stay idle with an empty change mask.
        send_word(8'h00);
        send_word(8'hFF);
        send_word(8'h00);
        send_word(8'h55);
        send_word(8'hAA);
        send_word(8'h01);
        send_word(8'h80);
        send_word(8'hFF);
        send_word(8'hFF);
        send_word(8'hFF);
        send_word(8'h7E);
        send_word(8'h81);

        // Directed, all thresholds zero: a held press walks short, long and
        // superlong press on consecutive ticks, release gives superlong released,
        // and a new press starts again from a released state. The last two groups
        // release one half while pressing the other.
        drain();
        load_thresholds(0, 0, 0);
        repeat (4) send_word(8'hFF);
        repeat (3) send_word(8'h00);
        repeat (2) send_word(8'hFF);
        repeat (3) send_word(8'hF0);
        repeat (2) send_word(8'h0F);
        held_levels = 8'h0F;

        // Random phases over a spread of thresholds, from zero to the maximum
        // (where no count can ever exceed the debounce) and with the superlong
        // threshold below the long one.
        run_phase(0, 0, 0, 100);
        run_phase(1, 3, 6, 150);
        repeat (3) begin
            run_phase($urandom_range(0, 4), $urandom_range(0, 20), $urandom_range(0, 40), 120);
        end
        run_phase(3, 10, 5, 100);
        run_phase(65535, 65535, 65535, 40);

        // Back to the reset thresholds, long enough for lanes to reach long press.
        run_phase(DEBOUNCE_RESET, LONG_RESET, SUPERLONG_RESET, 1100);

        drain();
        $display("Sent %0d words, checked %0d results; %0d moves to long, %0d to superlong.",
                 words_in, results_out, long_hits, super_hits);
        $display("Thresholds ran from zero to 65535 with random stalls and drains on both sides.");
        if (fail_count == 0 && due_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("Timeout: %0d words sent, %0d results still expected", words_in, due_count);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bpdc_pkg.sv
rtl/bpdc_lane.sv
rtl/bpdc_merge.sv
rtl/button_press_duration_classifier.sv
dv/bpdc_tick_check.sv
dv/tb.sv
